>>> design/qsu_pkg.sv
// Shared types, codes and character helpers for the quoted string unescape block.
// Used by the interfaces-side modules: front, queue, back and top level.
`timescale 1ns / 1ps
`default_nettype none

package qsu_pkg;

  // Transaction kinds on the character channel
  localparam logic KIND_OPEN = 1'b0;
  localparam logic KIND_CHAR = 1'b1;

  // Quote modes
  localparam logic [1:0] QM_SINGLE   = 2'd0;
  localparam logic [1:0] QM_DOUBLE   = 2'd1;
  localparam logic [1:0] QM_BACKTICK = 2'd2;

  // Spare quote type code, folded into backtick mode on open
  localparam logic [1:0] QT_BACKTICK_ALT = 2'd3;

  // Completion status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_LONG   = 2'd1;
  localparam logic [1:0] ST_UNTERM = 2'd2;

  // Characters with a special role
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  localparam logic [8:0] LINES_MAX = 9'd511;

  // Results one character can cause at most
  localparam int MAX_RES = 3;

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_ESC  = 6'b000010,
    PH_HEXX = 6'b000100,
    PH_HEX1 = 6'b001000,
    PH_OCT1 = 6'b010000,
    PH_OCT2 = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
    logic [1:0] status;
    logic [8:0] total_length;
    logic [8:0] newline_count;
  } res_t;

  // All results of one character, in order
  typedef struct packed {
    logic [1:0]              cnt;
    res_t [MAX_RES-1:0]      res;
  } bundle_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  // {valid, value} of a hex digit
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  // {valid, value} of an octal digit
  function automatic logic [3:0] oct_val(logic [7:0] c);
    logic [3:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h37) r = {1'b1, c[2:0]};
    return r;
  endfunction

  // {hit, byte} for the double-quote and backtick escape set
  function automatic logic [8:0] dq_escape(logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h6E:     r = {1'b1, 8'h0A};
      8'h72:     r = {1'b1, 8'h0D};
      8'h74:     r = {1'b1, 8'h09};
      8'h76:     r = {1'b1, 8'h0B};
      8'h66:     r = {1'b1, 8'h0C};
      CH_BSLASH: r = {1'b1, CH_BSLASH};
      CH_DQUOTE: r = {1'b1, CH_DQUOTE};
      default:   r = '0;
    endcase
    return r;
  endfunction

  // {hit, byte} for the single-quote escape set
  function automatic logic [8:0] sq_escape(logic [7:0] c);
    logic [8:0] r;
    r = '0;
    if (c == CH_BSLASH || c == CH_SQUOTE) r = {1'b1, c};
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/qsu_in_if.sv
// Character channel interface: valid/ready handshake with one string character.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

interface qsu_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] ch;
  logic [1:0] quote_type;
  logic [8:0] start_length;

  modport source (output valid, kind, ch, quote_type, start_length, input ready);
  modport sink   (input valid, kind, ch, quote_type, start_length, output ready);
endinterface

`default_nettype wire

>>> design/qsu_out_if.sv
// Result channel interface: valid/ready handshake with one decoded result.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

interface qsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last;
  logic [1:0] status;
  logic [8:0] total_length;
  logic [8:0] newline_count;

  modport source (output valid, data_byte, byte_valid, last, status, total_length,
                  newline_count, input ready);
  modport sink   (input valid, data_byte, byte_valid, last, status, total_length,
                  newline_count, output ready);
endinterface

`default_nettype wire

>>> design/qsu_front.sv
// Front end: accepts characters, runs the escape decoder, builds result bundles.
// Depends on qsu_pkg and qsu_in_if.
`timescale 1ns / 1ps
`default_nettype none

module qsu_front #(
  parameter int MAX_LEN = 256
) (
  input  logic             clk,
  input  logic             rst,
  qsu_in_if.sink           chars,
  output logic             push,
  output qsu_pkg::bundle_t push_data,
  input  qsu_pkg::qstat_t  qstat
);
  import qsu_pkg::*;

  // Count can pass the limit by a few escape bytes and start above it
  localparam int CNT_W = $clog2(MAX_LEN + 516);

  typedef struct packed {
    logic               act;
    phase_t             ph;
    logic [5:0]         pend;
    logic [CNT_W-1:0]   cnt;
    logic [8:0]         lines;
    logic [1:0]         n;
    res_t [MAX_RES-1:0] res;
  } dec_t;

  logic             active;
  logic [1:0]       quote_mode;
  phase_t           phase;
  logic [5:0]       pending;
  logic [CNT_W-1:0] out_count;
  logic [8:0]       line_count;

  logic       accept;
  logic [7:0] qc;
  logic [4:0] hx;
  logic [3:0] oc;
  logic [8:0] esc;
  dec_t       d;

  function automatic dec_t put(dec_t s, res_t r);
    s.res[s.n] = r;
    s.n        = s.n + 2'd1;
    return s;
  endfunction

  function automatic dec_t emit(dec_t s, logic [7:0] b);
    res_t r;
    r            = '0;
    r.data_byte  = b;
    r.byte_valid = 1'b1;
    s.cnt        = s.cnt + CNT_W'(1);
    return put(s, r);
  endfunction

  function automatic dec_t finish(dec_t s, logic [1:0] st);
    res_t r;
    r               = '0;
    r.last          = 1'b1;
    r.status        = st;
    r.total_length  = s.cnt[8:0];
    r.newline_count = s.lines;
    s.act           = 1'b0;
    s.ph            = PH_IDLE;
    return put(s, r);
  endfunction

  // Plain character outside an escape
  function automatic dec_t raw(dec_t s, logic [7:0] c, logic [7:0] q);
    dec_t t;
    t = s;
    if (c == CH_NUL) t = finish(s, ST_UNTERM);
    else if (c == q) t = finish(s, ST_OK);
    else if (s.cnt >= CNT_W'(MAX_LEN)) t = finish(s, ST_LONG);
    else if (c == CH_BSLASH) t.ph = PH_ESC;
    else begin
      if (c == CH_LF && s.lines != LINES_MAX) t.lines = s.lines + 9'd1;
      t = emit(t, c);
    end
    return t;
  endfunction

  assign accept      = chars.valid && chars.ready;
  assign chars.ready = !qstat.full;

  always_comb begin
    unique case (quote_mode)
      QM_SINGLE: qc = CH_SQUOTE;
      QM_DOUBLE: qc = CH_DQUOTE;
      default:   qc = CH_BTICK;
    endcase
  end

  assign hx  = hex_val(chars.ch);
  assign oc  = oct_val(chars.ch);
  assign esc = (quote_mode == QM_SINGLE) ? sq_escape(chars.ch) : dq_escape(chars.ch);

  always_comb begin
    d       = '0;
    d.act   = active;
    d.ph    = phase;
    d.pend  = pending;
    d.cnt   = out_count;
    d.lines = line_count;
    if (chars.kind == KIND_CHAR && active) begin
      unique case (phase)
        PH_ESC: begin
          if (chars.ch == CH_NUL) d = finish(d, ST_UNTERM);
          else begin
            d.ph = PH_IDLE;
            if (esc[8]) d = emit(d, esc[7:0]);
            else if (quote_mode == QM_DOUBLE && oc[3] && oc[2:0] == 3'd0) d = emit(d, CH_NUL);
            else if (quote_mode == QM_DOUBLE && oc[3]) begin
              d.pend = {3'd0, oc[2:0]};
              d.ph   = PH_OCT1;
            end else if (quote_mode == QM_DOUBLE && chars.ch == CH_X) d.ph = PH_HEXX;
            else begin
              // unknown escape: keep the backslash, redo the character
              d = emit(d, CH_BSLASH);
              d = raw(d, chars.ch, qc);
            end
          end
        end
        PH_HEXX: begin
          if (hx[4]) begin
            d.pend = {2'd0, hx[3:0]};
            d.ph   = PH_HEX1;
          end else if (chars.ch == CH_NUL) d = finish(d, ST_UNTERM);
          else begin
            d.ph = PH_IDLE;
            d    = emit(d, CH_BSLASH);
            d    = raw(d, CH_X, qc);
            if (d.act) d = raw(d, chars.ch, qc);
          end
        end
        PH_HEX1: begin
          if (hx[4]) begin
            d.ph = PH_IDLE;
            d    = emit(d, {pending[3:0], hx[3:0]});
          end else if (chars.ch == CH_NUL) d = finish(d, ST_UNTERM);
          else begin
            d.ph = PH_IDLE;
            d    = emit(d, {2'd0, pending});
            d    = raw(d, chars.ch, qc);
          end
        end
        PH_OCT1: begin
          if (oc[3]) begin
            d.pend = {pending[2:0], oc[2:0]};
            d.ph   = PH_OCT2;
          end else if (chars.ch == CH_NUL) d = finish(d, ST_UNTERM);
          else begin
            d.ph = PH_IDLE;
            d    = emit(d, {2'd0, pending});
            d    = raw(d, chars.ch, qc);
          end
        end
        PH_OCT2: begin
          if (oc[3]) begin
            // values above 255 keep their low byte
            d.ph = PH_IDLE;
            d    = emit(d, {pending[4:0], oc[2:0]});
          end else if (chars.ch == CH_NUL) d = finish(d, ST_UNTERM);
          else begin
            d.ph = PH_IDLE;
            d    = emit(d, {2'd0, pending});
            d    = raw(d, chars.ch, qc);
          end
        end
        default: begin
          d.ph = PH_IDLE;
          d    = raw(d, chars.ch, qc);
        end
      endcase
    end
  end

  assign push          = accept && chars.kind == KIND_CHAR && d.n != 2'd0;
  assign push_data.cnt = d.n;
  assign push_data.res = d.res;

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      quote_mode <= QM_SINGLE;
      phase      <= PH_IDLE;
      pending    <= '0;
      out_count  <= '0;
      line_count <= '0;
    end else if (accept) begin
      if (chars.kind == KIND_OPEN) begin
        // drop any open string and start fresh
        active     <= 1'b1;
        quote_mode <= (chars.quote_type == QT_BACKTICK_ALT) ? QM_BACKTICK : chars.quote_type;
        phase      <= PH_IDLE;
        pending    <= '0;
        out_count  <= CNT_W'(chars.start_length);
        line_count <= '0;
      end else begin
        active     <= d.act;
        phase      <= d.ph;
        pending    <= d.pend;
        out_count  <= d.cnt;
        line_count <= d.lines;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/qsu_queue.sv
// Bundle queue between decoder front and result back end.
// Depends on qsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qsu_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  qsu_pkg::bundle_t push_data,
  input  logic             pop,
  output qsu_pkg::bundle_t head,
  output qsu_pkg::qstat_t  qstat
);
  import qsu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] adv(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign head        = mem[rd_ptr];
  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= adv(wr_ptr);
      if (pop)  rd_ptr <= adv(rd_ptr);
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/qsu_back.sv
// Back end: walks each bundle and drives one result per cycle into the output register while result.ready allows.
// Depends on qsu_pkg and qsu_out_if.
`timescale 1ns / 1ps
`default_nettype none

module qsu_back (
  input  logic             clk,
  input  logic             rst,
  input  qsu_pkg::bundle_t head,
  input  qsu_pkg::qstat_t  qstat,
  output logic             pop,
  qsu_out_if.source        result
);
  import qsu_pkg::*;

  logic [1:0] idx;
  logic       load;
  res_t       cur;

  assign load = !qstat.empty && (!result.valid || result.ready);
  assign cur  = head.res[idx];
  assign pop  = load && (idx == head.cnt - 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      idx          <= '0;
    end else if (load) begin
      result.valid <= 1'b1;
      idx          <= pop ? 2'd0 : idx + 2'd1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.data_byte     <= cur.data_byte;
      result.byte_valid    <= cur.byte_valid;
      result.last          <= cur.last;
      result.status        <= cur.status;
      result.total_length  <= cur.total_length;
      result.newline_count <= cur.newline_count;
    end
  end

endmodule

`default_nettype wire

>>> design/quoted_string_unescape.sv
// Top level of the quoted string unescape block: front decoder, bundle queue, back end.
// Depends on qsu_pkg, qsu_in_if, qsu_out_if, qsu_front, qsu_queue, qsu_back.
//
//   channel  | role   | carries
//   ---------+--------+----------------------------------------------------------
//   chars    | sink   | kind, ch, quote_type, start_length (open or one character)
//   result   | source | data_byte, byte_valid, last, status, total_length,
//            |        | newline_count (one decoded byte or one end-of-string mark)
//
// Cycles: one character transaction per cycle unless the queue is full; the decoder
//   finishes it in the cycle it is taken. Each character yields zero to three results,
//   which leave one per cycle while result.ready holds, so the result port sets the
//   sustained rate when strings expand.
// Stalls: the bundle queue (QUEUE_DEPTH entries) lets the front keep taking
//   characters while the back end waits on result.ready; chars.ready drops only
//   when the queue is full.
// Reset: synchronous; clears decoder state, queue pointers and output valid.
`timescale 1ns / 1ps
`default_nettype none

module quoted_string_unescape #(
  parameter int MAX_LEN     = 256,
  parameter int QUEUE_DEPTH = 4
) (
  input logic        clk,
  input logic        rst,
  qsu_in_if.sink     chars,
  qsu_out_if.source  result
);
  import qsu_pkg::*;

  logic    push;
  bundle_t push_data;
  bundle_t head;
  qstat_t  qstat;
  logic    pop;

  // Decode each character into a bundle of results
  qsu_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars),
    .push      (push),
    .push_data (push_data),
    .qstat     (qstat)
  );

  // Hold bundles until the back end has drained them
  qsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // Serialize bundles onto the result channel
  qsu_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .qstat  (qstat),
    .pop    (pop),
    .result (result)
  );

  // An end-of-string mark never carries a byte
  a_last_no_byte: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.last && result.byte_valid))
    else $error("end mark carries a data byte");

  // Bundles come only from accepted body characters
  a_push_from_char: assert property (@(posedge clk) disable iff (rst)
    push |-> (chars.valid && chars.ready && chars.kind == KIND_CHAR))
    else $error("bundle pushed without an accepted character");

  // The back end never takes from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

  // Queued work reaches the output register in the next cycle when it is free
  a_back_loads: assert property (@(posedge clk) disable iff (rst)
    (!qstat.empty && !result.valid) |=> result.valid)
    else $error("back end idle with work queued");

endmodule

`default_nettype wire
